FILE: hdl/hhn_pkg.sv
package hhn_pkg;

  // image store
  localparam int ADDR_W        = 16;
  localparam int PIXEL_DEPTH   = 1 << ADDR_W;
  localparam int PIX_W         = 24;
  localparam int CHAN_W        = 8;

  // configuration
  localparam int CFG_W         = 9;
  localparam int ALT_W         = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = ALT_W;
  localparam int MAX_GRID_SIDE = 256;

  localparam logic [CFG_W-1:0] VERTEX_COUNT_RST   = CFG_W'(64);
  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST    = CFG_W'(256);
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST   = CFG_W'(256);
  localparam logic [ALT_W-1:0] ALTITUDE_SCALE_RST = ALT_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTEX_COUNT   = 2'd0,
    REG_IMAGE_WIDTH    = 2'd1,
    REG_IMAGE_HEIGHT   = 2'd2,
    REG_ALTITUDE_SCALE = 2'd3
  } cfg_reg_t;

  // item kinds
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_VERTEX = 1'b1;

  // stream payloads
  localparam int GRID_W      = 8;
  localparam int IN_DATA_W   = ADDR_W + 3 * CHAN_W + 2 * GRID_W;
  localparam int HGT_W       = 24;
  localparam int NRM_W       = 16;
  localparam int NRM_Y_W     = 15;
  localparam int OUT_FIELD_W = HGT_W + NRM_W + NRM_Y_W + NRM_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  // shared multiplier and subtractor
  localparam int MUL_W   = HGT_W + 1;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SQ_W    = 2 * HGT_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int SUB_W   = SUM_W + 1;
  localparam int LIM_W   = 2 * CFG_W;
  localparam int ADR_S_W = 29;
  localparam int POS_W   = GRID_W + 2;

  // normal evaluation
  localparam int QUO_W       = 30;
  localparam int SQRT_STEPS  = QUO_W / 2;
  localparam int ROOT_W      = SQRT_STEPS + 1;
  localparam int CNT_W       = 5;
  localparam logic [SUM_W-1:0] FLAT_SQ = SUM_W'(512 * 512);
  localparam logic [ROOT_W-1:0] NRM_MAX = ROOT_W'(32767);

  // sample positions around a vertex
  localparam int NUM_SAMPLES = 5;
  localparam logic [2:0] SMP_CENTER = 3'd0;
  localparam logic [2:0] SMP_ROW_DN = 3'd1;
  localparam logic [2:0] SMP_ROW_UP = 3'd2;
  localparam logic [2:0] SMP_COL_DN = 3'd3;
  localparam logic [2:0] SMP_COL_UP = 3'd4;

  // normal components
  localparam logic [1:0] CMP_X = 2'd0;
  localparam logic [1:0] CMP_Y = 2'd1;
  localparam logic [1:0] CMP_Z = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIV,
    ST_LIM,
    ST_LIMW,
    ST_A1,
    ST_A2,
    ST_A3,
    ST_A4,
    ST_A5,
    ST_A6,
    ST_A7,
    ST_A8,
    ST_N1,
    ST_N2,
    ST_N3,
    ST_N4,
    ST_CINIT,
    ST_CDIV,
    ST_CSQRT,
    ST_CEND,
    ST_DONE
  } state_t;

endpackage

FILE: hdl/heightmap_height_and_normal.sv
// a pixel load is written to the store while the sequencer stays idle, so the block stays ready
// a vertex holds s_axis_tready low from acceptance until its result enters the output register;
// its steps run on the single shared subtractor, which does the stride divisions,
// the 30-step normal divisions and the 15-step square roots; a flat vertex skips the y division and root
// reset: config registers go to their defaults, the sequencer to idle, the output empty;
// the pixel store is not cleared and holds garbage until written
module heightmap_height_and_normal
  import hhn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pixel_index, red, green, blue, vertex_row, vertex_col
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // height, normal_x, normal_y, normal_z, one pad bit
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [CFG_W-1:0] vertex_count;
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [ALT_W-1:0] altitude_scale;
  logic [CFG_W-1:0] vc_eff;

  // input item fields
  logic              in_fire;
  logic [ADDR_W-1:0] in_pixel_index;
  logic [PIX_W-1:0]  in_pixel;
  logic [GRID_W-1:0] in_row;
  logic [GRID_W-1:0] in_col;

  // sequencer
  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [2:0]       k;
  logic [1:0]       j;
  logic             div_sel;

  // vertex working registers
  logic [GRID_W-1:0]  row;
  logic [GRID_W-1:0]  col;
  logic [CFG_W-1:0]   stride_row;
  logic [CFG_W-1:0]   stride_col;
  logic [LIM_W-1:0]   limit;
  logic [ADR_S_W-1:0] addr_row;
  logic [ADR_S_W-1:0] samp_addr;
  logic               in_img;
  logic [PIX_W-1:0]   mem_rd;
  logic [HGT_W-1:0]   hs [NUM_SAMPLES];
  logic signed [POS_W-1:0] samp_row;
  logic signed [POS_W-1:0] samp_col;

  // normal working registers
  logic signed [HGT_W:0] dx;
  logic signed [HGT_W:0] dz;
  logic signed [HGT_W:0] ax;
  logic signed [HGT_W:0] az;
  logic [SQ_W-1:0]       sq_x;
  logic [SQ_W-1:0]       sq_z;
  logic [SUM_W-1:0]      sum;
  logic [SUB_W-1:0]      cnum;
  logic [SUB_W-1:0]      rem;
  logic [QUO_W-1:0]      quo;
  logic [ROOT_W-1:0]     root;
  logic [NRM_W-1:0]      mag;
  logic [NRM_W-1:0]      nx;
  logic [NRM_Y_W-1:0]    ny;
  logic [NRM_W-1:0]      nz;

  // shared multiplier and subtractor
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [SUB_W-1:0]         sub_a;
  logic [SUB_W-1:0]         sub_b;
  logic [SUB_W:0]           sub_d;
  logic                     sub_ge;

  // output register
  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  // image store, no reset: users ensure entries are read only after a load wrote them; not enforced
  logic [PIX_W-1:0] pixel_store [PIXEL_DEPTH];

  assign in_pixel_index = s_axis_tdata[ADDR_W-1:0];
  assign in_pixel       = {s_axis_tdata[ADDR_W +: CHAN_W],
                           s_axis_tdata[ADDR_W+CHAN_W +: CHAN_W],
                           s_axis_tdata[ADDR_W+2*CHAN_W +: CHAN_W]};
  assign in_row         = s_axis_tdata[ADDR_W+3*CHAN_W +: GRID_W];
  assign in_col         = s_axis_tdata[ADDR_W+3*CHAN_W+GRID_W +: GRID_W];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count   <= VERTEX_COUNT_RST;
      image_width    <= IMAGE_WIDTH_RST;
      image_height   <= IMAGE_HEIGHT_RST;
      altitude_scale <= ALTITUDE_SCALE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VERTEX_COUNT:   vertex_count   <= cfg_data[CFG_W-1:0];
        REG_IMAGE_WIDTH:    image_width    <= cfg_data[CFG_W-1:0];
        REG_IMAGE_HEIGHT:   image_height   <= cfg_data[CFG_W-1:0];
        REG_ALTITUDE_SCALE: altitude_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // grid side clamped to 1..MAX_GRID_SIDE
  always_comb begin
    if (vertex_count == '0) begin
      vc_eff = CFG_W'(1);
    end else if (vertex_count > CFG_W'(MAX_GRID_SIDE)) begin
      vc_eff = CFG_W'(MAX_GRID_SIDE);
    end else begin
      vc_eff = vertex_count;
    end
  end

  // grid position of the sample being fetched
  always_comb begin
    samp_row = $signed(POS_W'(row));
    samp_col = $signed(POS_W'(col));
    case (k)
      SMP_ROW_DN: samp_row = $signed(POS_W'(row)) - POS_W'(1);
      SMP_ROW_UP: samp_row = $signed(POS_W'(row)) + POS_W'(1);
      SMP_COL_DN: samp_col = $signed(POS_W'(col)) - POS_W'(1);
      SMP_COL_UP: samp_col = $signed(POS_W'(col)) + POS_W'(1);
      default: ;
    endcase
  end

  // linear address: row part plus column part, two's complement
  assign samp_addr = addr_row + mul_p[ADR_S_W-1:0];

  assign ax = dx[HGT_W] ? -dx : dx;
  assign az = dz[HGT_W] ? -dz : dz;

  // numerator of the component in work
  always_comb begin
    case (j)
      CMP_X:   cnum = SUB_W'(sq_x);
      CMP_Y:   cnum = SUB_W'(FLAT_SQ);
      default: cnum = SUB_W'(sq_z);
    endcase
  end

  assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge = ~sub_d[SUB_W];

  // shared multiplier, product always registered
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and shared unit operands
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    sub_a      = '0;
    sub_b      = '0;
    case (state)
      ST_IDLE: begin
        if (in_fire && s_axis_tuser == OP_VERTEX) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        // one restoring step of the stride division
        sub_a = SUB_W'({rem[CFG_W-1:0], quo[CFG_W-1]});
        sub_b = SUB_W'(vc_eff);
        if (cnt == CNT_W'(CFG_W - 1) && div_sel) begin
          state_next = ST_LIM;
        end
      end
      ST_LIM: begin
        mul_a      = $signed(MUL_W'(image_width));
        mul_b      = $signed(MUL_W'(image_height));
        state_next = ST_LIMW;
      end
      ST_LIMW: state_next = ST_A1;
      ST_A1: begin
        mul_a      = MUL_W'(samp_row);
        mul_b      = $signed(MUL_W'(stride_row));
        state_next = ST_A2;
      end
      ST_A2: begin
        mul_a      = $signed(mul_p[MUL_W-1:0]);
        mul_b      = $signed(MUL_W'(image_width));
        state_next = ST_A3;
      end
      ST_A3: begin
        mul_a      = MUL_W'(samp_col);
        mul_b      = $signed(MUL_W'(stride_col));
        state_next = ST_A4;
      end
      ST_A4: state_next = ST_A5;
      ST_A5: begin
        mul_a      = $signed(MUL_W'(mem_rd[PIX_W-1 -: CHAN_W]));
        mul_b      = $signed(MUL_W'(mem_rd[CHAN_W +: CHAN_W]));
        state_next = ST_A6;
      end
      ST_A6: begin
        mul_a      = $signed(MUL_W'(mul_p[2*CHAN_W-1:0]));
        mul_b      = $signed(MUL_W'(mem_rd[CHAN_W-1:0]));
        state_next = ST_A7;
      end
      ST_A7: begin
        mul_a      = $signed(MUL_W'(mul_p[PIX_W-1:0]));
        mul_b      = $signed(MUL_W'(altitude_scale));
        state_next = ST_A8;
      end
      ST_A8: begin
        if (k == 3'(NUM_SAMPLES - 1)) begin
          state_next = ST_N1;
        end else begin
          state_next = ST_A1;
        end
      end
      ST_N1: state_next = ST_N2;
      ST_N2: begin
        mul_a      = ax;
        mul_b      = ax;
        state_next = ST_N3;
      end
      ST_N3: begin
        mul_a      = az;
        mul_b      = az;
        state_next = ST_N4;
      end
      ST_N4: state_next = ST_CINIT;
      ST_CINIT: begin
        // numerator not below the sum only for a flat y, which saturates
        sub_a = cnum;
        sub_b = SUB_W'(sum);
        if (sub_ge) begin
          state_next = ST_CEND;
        end else begin
          state_next = ST_CDIV;
        end
      end
      ST_CDIV: begin
        sub_a = {rem[SUB_W-2:0], 1'b0};
        sub_b = SUB_W'(sum);
        if (cnt == CNT_W'(QUO_W - 1)) begin
          state_next = ST_CSQRT;
        end
      end
      ST_CSQRT: begin
        // one root bit per step from two quotient bits
        sub_a = {rem[SUB_W-3:0], quo[QUO_W-1 -: 2]};
        sub_b = SUB_W'({root, 2'b01});
        if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
          state_next = ST_CEND;
        end
      end
      ST_CEND: begin
        if (j == CMP_Z) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_CINIT;
        end
      end
      ST_DONE: begin
        if (!out_valid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // pixel loads and sample reads
  always_ff @(posedge clk) begin
    if (in_fire && s_axis_tuser == OP_LOAD) begin
      pixel_store[in_pixel_index] <= in_pixel;
    end
    if (state == ST_A4) begin
      mem_rd <= pixel_store[samp_addr[ADDR_W-1:0]];
    end
  end

  assign mag = NRM_W'(root[NRM_W-2:0]);

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        row     <= in_row;
        col     <= in_col;
        rem     <= '0;
        quo     <= QUO_W'(image_width);
        cnt     <= '0;
        div_sel <= 1'b0;
      end
      ST_DIV: begin
        if (cnt == CNT_W'(CFG_W - 1)) begin
          if (!div_sel) begin
            stride_row <= {quo[CFG_W-2:0], sub_ge};
          end else begin
            stride_col <= {quo[CFG_W-2:0], sub_ge};
          end
          // second pass divides the image height
          rem     <= '0;
          quo     <= QUO_W'(image_height);
          cnt     <= '0;
          div_sel <= 1'b1;
        end else begin
          rem <= sub_ge ? sub_d[SUB_W-1:0] : sub_a;
          quo <= {quo[QUO_W-2:0], sub_ge};
          cnt <= cnt + CNT_W'(1);
        end
      end
      ST_LIMW: begin
        limit <= mul_p[LIM_W-1:0];
        k     <= SMP_CENTER;
      end
      ST_A3: addr_row <= mul_p[ADR_S_W-1:0];
      ST_A4: begin
        // negative, past the image or past the store reads as zero height
        in_img <= ~samp_addr[ADR_S_W-1]
                  && (samp_addr[ADR_S_W-2:0] < (ADR_S_W-1)'(limit))
                  && (samp_addr[ADR_S_W-2:0] < (ADR_S_W-1)'(PIXEL_DEPTH));
      end
      ST_A8: begin
        hs[k] <= in_img ? mul_p[ALT_W +: HGT_W] : '0;
        k     <= k + 3'd1;
      end
      ST_N1: begin
        dx <= $signed({1'b0, hs[SMP_ROW_DN]}) - $signed({1'b0, hs[SMP_ROW_UP]});
        dz <= $signed({1'b0, hs[SMP_COL_DN]}) - $signed({1'b0, hs[SMP_COL_UP]});
      end
      ST_N3: sq_x <= mul_p[SQ_W-1:0];
      ST_N4: begin
        sq_z <= mul_p[SQ_W-1:0];
        sum  <= SUM_W'(sq_x) + SUM_W'(mul_p[SQ_W-1:0]) + FLAT_SQ;
        j    <= CMP_X;
      end
      ST_CINIT: begin
        rem  <= cnum;
        cnt  <= '0;
        root <= NRM_MAX;
      end
      ST_CDIV: begin
        quo <= {quo[QUO_W-2:0], sub_ge};
        if (cnt == CNT_W'(QUO_W - 1)) begin
          rem  <= '0;
          root <= '0;
          cnt  <= '0;
        end else begin
          rem <= sub_ge ? sub_d[SUB_W-1:0] : sub_a;
          cnt <= cnt + CNT_W'(1);
        end
      end
      ST_CSQRT: begin
        rem  <= sub_ge ? sub_d[SUB_W-1:0] : sub_a;
        root <= {root[ROOT_W-2:0], sub_ge};
        quo  <= {quo[QUO_W-3:0], 2'b00};
        cnt  <= cnt + CNT_W'(1);
      end
      ST_CEND: begin
        case (j)
          CMP_X:   nx <= dx[HGT_W] ? NRM_W'(0) - mag : mag;
          CMP_Y:   ny <= root[NRM_Y_W-1:0];
          default: nz <= dz[HGT_W] ? NRM_W'(0) - mag : mag;
        endcase
        j <= j + 2'd1;
      end
      default: ;
    endcase
  end

  // output register, frees the sequencer while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || m_axis_tready)) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || m_axis_tready)) begin
      out_data <= OUT_DATA_W'({nz, ny, nx, hs[SMP_CENTER]});
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import hhn_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  // wait before the final verdict, so that any stray result still in flight is seen
  localparam int DRAIN_CYCLES = 250;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // pixel_index, red, green, blue, vertex_row, vertex_col
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  // op
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // height, normal_x, normal_y, normal_z, one pad bit
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  heightmap_height_and_normal i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // one expected vertex result
  typedef struct {
    logic [HGT_W-1:0]   height;
    logic [NRM_W-1:0]   normal_x;
    logic [NRM_Y_W-1:0] normal_y;
    logic [NRM_W-1:0]   normal_z;
  } vertex_result_t;

  // mirror of the image store and registers, predicts height and normal per vertex
  class heightmap_scoreboard;
    logic [PIX_W-1:0] pixel_mem [PIXEL_DEPTH];
    bit               pixel_written [PIXEL_DEPTH];
    logic [CFG_W-1:0] vertex_count;
    logic [CFG_W-1:0] image_width;
    logic [CFG_W-1:0] image_height;
    logic [ALT_W-1:0] altitude_scale;
    vertex_result_t   expected_vertices [$];
    int               mismatches;

    function new();
      vertex_count   = VERTEX_COUNT_RST;
      image_width    = IMAGE_WIDTH_RST;
      image_height   = IMAGE_HEIGHT_RST;
      altitude_scale = ALTITUDE_SCALE_RST;
      mismatches     = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_VERTEX_COUNT:   vertex_count   = value[CFG_W-1:0];
        REG_IMAGE_WIDTH:    image_width    = value[CFG_W-1:0];
        REG_IMAGE_HEIGHT:   image_height   = value[CFG_W-1:0];
        REG_ALTITUDE_SCALE: altitude_scale = value;
        default: ;
      endcase
    endfunction

    // linear store address of grid point (r, c), or -1 when it falls outside the image or the store
    function longint sample_addr(longint r, longint c);
      longint vc, sr, sc, addr, lim;
      vc = longint'(vertex_count);
      if (vc < 1) vc = 1;
      if (vc > MAX_GRID_SIDE) vc = MAX_GRID_SIDE;
      sr   = longint'(image_width) / vc;
      sc   = longint'(image_height) / vc;
      addr = longint'(image_width) * (r * sr) + c * sc;
      lim  = longint'(image_width) * longint'(image_height);
      if (addr < 0 || addr >= lim || addr >= PIXEL_DEPTH) return -1;
      return addr;
    endfunction

    // height in q.8: r*g*b*scale / 2^16
    function longint sample_height(longint r, longint c);
      longint           addr;
      logic [PIX_W-1:0] px;
      addr = sample_addr(r, c);
      if (addr < 0) return 0;
      px = pixel_mem[addr];
      return (longint'(px[23:16]) * longint'(px[15:8]) * longint'(px[7:0])
              * longint'(altitude_scale)) >> 16;
    endfunction

    // floor(sqrt(floor(n * 2^30 / s))), saturating when n >= s
    function logic [NRM_Y_W-1:0] unit_root(longint unsigned n, longint unsigned s);
      logic [95:0] quo;
      logic [29:0] q;
      logic [15:0] root;
      logic [15:0] trial;
      if (s == 0 || n >= s) return NRM_Y_W'(32767);
      quo  = ({32'd0, n} << 30) / {32'd0, s};
      q    = quo[29:0];
      root = '0;
      for (int b = 14; b >= 0; b--) begin
        trial = root | (16'd1 << b);
        if (32'(trial) * 32'(trial) <= 32'(q)) root = trial;
      end
      return root[NRM_Y_W-1:0];
    endfunction

    function logic [NRM_W-1:0] signed_part(longint d, longint unsigned s);
      longint unsigned    mag;
      logic [NRM_Y_W-1:0] m;
      mag = (d < 0) ? -d : d;
      m   = unit_root(mag * mag, s);
      return (d < 0) ? -{1'b0, m} : {1'b0, m};
    endfunction

    function void note_item(logic op, logic [IN_DATA_W-1:0] data);
      longint          r, c, h, dx, dz;
      longint unsigned sq;
      vertex_result_t  res;
      if (op == OP_LOAD) begin
        pixel_mem[data[15:0]]     = {data[23:16], data[31:24], data[39:32]};
        pixel_written[data[15:0]] = 1'b1;
        return;
      end
      r  = longint'(data[47:40]);
      c  = longint'(data[55:48]);
      h  = sample_height(r, c);
      dx = sample_height(r - 1, c) - sample_height(r + 1, c);
      dz = sample_height(r, c - 1) - sample_height(r, c + 1);
      sq = dx * dx + 512 * 512 + dz * dz;
      res.height   = h[HGT_W-1:0];
      res.normal_x = signed_part(dx, sq);
      res.normal_y = unit_root(64'(512 * 512), sq);
      res.normal_z = signed_part(dz, sq);
      expected_vertices = {expected_vertices, res};
    endfunction

    function void compare_field(string name, logic [HGT_W-1:0] want, logic [HGT_W-1:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_vertex(logic [OUT_DATA_W-1:0] data);
      vertex_result_t want;
      if (expected_vertices.size() == 0) begin
        $error("vertex result with none expected: %0h", data);
        mismatches++;
        return;
      end
      want = expected_vertices.pop_front();
      compare_field("height",   want.height,   data[23:0]);
      compare_field("normal_x", HGT_W'(want.normal_x), HGT_W'(data[39:24]));
      compare_field("normal_y", HGT_W'(want.normal_y), HGT_W'(data[54:40]));
      compare_field("normal_z", HGT_W'(want.normal_z), HGT_W'(data[70:55]));
    endfunction
  endclass

  heightmap_scoreboard sb = new();

  int          items_sent  = 0;
  int          burst_left  = 0;
  int          sink_left   = 0;
  int          sink_mode   = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: stretches of always-ready, coin-flip, sparse and solid stall
  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_mode = $urandom_range(0, 3);
      sink_left = $urandom_range(8, 80);
    end
    sink_left--;
    case (sink_mode)
      0: m_axis_tready = 1'b1;
      1: m_axis_tready = 1'($urandom_range(0, 1));
      2: m_axis_tready = ($urandom_range(0, 7) == 0);
      default: m_axis_tready = 1'b0;
    endcase
  end

  // every accepted result goes straight to the scoreboard
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_vertex(m_axis_tdata);
  end

  // colors skewed toward extremes so that slopes get steep and flat areas appear
  function automatic logic [PIX_W-1:0] random_rgb();
    case ($urandom_range(0, 4))
      0: return 24'hffffff;
      1: return 24'h000000;
      2: return {8'($urandom_range(192, 255)), 8'($urandom_range(192, 255)),
                 8'($urandom_range(192, 255))};
      default: return 24'($urandom);
    endcase
  endfunction

  // one item on the input stream; the sender works in bursts with random gaps
  task automatic push_item(input logic op, input logic [IN_DATA_W-1:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 240) : $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = data;
    s_axis_tuser  = op;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(op, data);
    items_sent++;
  endtask

  // row and column fields are don't-care on a load, so they carry noise
  task automatic load_pixel(input logic [ADDR_W-1:0] idx, input logic [PIX_W-1:0] rgb);
    push_item(OP_LOAD, {8'($urandom), 8'($urandom), rgb[7:0], rgb[15:8], rgb[23:16], idx});
  endtask

  // any sample the vertex reads inside the image is written first, never read unwritten
  task automatic vertex_at(input logic [GRID_W-1:0] row, input logic [GRID_W-1:0] col);
    longint addr;
    int     dr [NUM_SAMPLES] = '{0, -1, 1, 0, 0};
    int     dc [NUM_SAMPLES] = '{0, 0, 0, -1, 1};
    for (int k = 0; k < NUM_SAMPLES; k++) begin
      addr = sb.sample_addr(longint'(row) + dr[k], longint'(col) + dc[k]);
      if (addr >= 0 && !sb.pixel_written[addr]) load_pixel(addr[ADDR_W-1:0], random_rgb());
    end
    push_item(OP_VERTEX, {col, row, 24'($urandom), 16'($urandom)});
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait until every vertex has come back; a load is written when it is accepted
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (sb.expected_vertices.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // mostly points on the configured grid, the rest anywhere in the 8-bit range
  function automatic logic [GRID_W-1:0] random_coord();
    int span;
    span = int'(sb.vertex_count);
    if (span < 1) span = 1;
    if (span > MAX_GRID_SIDE) span = MAX_GRID_SIDE;
    if ($urandom_range(0, 9) < 7) return GRID_W'($urandom_range(0, span - 1));
    return GRID_W'($urandom_range(0, 255));
  endfunction

  task automatic random_items(input int n_items);
    int stop_at;
    int area;
    int pick;
    stop_at = items_sent + n_items;
    area = int'(sb.image_width) * int'(sb.image_height);
    if (area > PIXEL_DEPTH) area = PIXEL_DEPTH;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        // stray load anywhere in the store
        load_pixel(16'($urandom), random_rgb());
      end else if (pick < 25 && area > 0) begin
        // overwrite a pixel inside the image so later vertices see new slopes
        load_pixel(ADDR_W'($urandom_range(0, area - 1)), random_rgb());
      end else begin
        vertex_at(random_coord(), random_coord());
      end
    end
  endtask

  task automatic run_phase(input int vc, input int w, input int h, input int alt,
                           input int n_items);
    settle();
    write_reg(REG_VERTEX_COUNT,   CFG_DATA_W'(vc));
    write_reg(REG_IMAGE_WIDTH,    CFG_DATA_W'(w));
    write_reg(REG_IMAGE_HEIGHT,   CFG_DATA_W'(h));
    write_reg(REG_ALTITUDE_SCALE, CFG_DATA_W'(alt));
    random_items(n_items);
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_LOAD;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_VERTEX_COUNT;
    cfg_data      = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, reset config: 64 vertices over 256x256, stride 4, address 1024*row + 4*col
    load_pixel(16'd0,     24'hffffff);
    load_pixel(16'd1024,  24'hffffff);
    load_pixel(16'd4,     24'h000000);
    load_pixel(16'd65535, 24'h010203);
    load_pixel(16'd65532, 24'hff00ff);
    // corner: upper and left neighbours fall at negative addresses
    vertex_at(8'd0, 8'd0);
    // far outside the grid, every sample beyond the store: height 0, flat normal
    vertex_at(8'd255, 8'd255);
    // last grid row inside the store, the row below runs past the store depth
    vertex_at(8'd63, 8'd255);
    settle();
    write_reg(REG_ALTITUDE_SCALE, CFG_DATA_W'(65535));
    // steepest slopes: full height on one side, zero on the other
    load_pixel(16'd2052, 24'hffffff);
    load_pixel(16'd1032, 24'h000000);
    load_pixel(16'd1028, 24'h808080);
    vertex_at(8'd1, 8'd1);
    vertex_at(8'd0, 8'd0);
    random_items(80);

    // configuration sweep, extremes first, then a few random setups
    run_phase(64,  256, 256, 100,   90);
    run_phase(2,   16,  16,  65535, 90);  // two vertices per side over a 16x16 image
    run_phase(256, 256, 256, 0,     90);  // zero scale, all flat
    run_phase(0,   1,   1,   5000,  90);  // count 0 acts as 1, one-pixel image
    run_phase(511, 511, 511, 65535, 90);  // count clamps to 256, image larger than store
    run_phase(7,   0,   200, 300,   60);  // zero width
    run_phase(3,   100, 0,   40000, 60);  // zero height
    run_phase(1,   256, 256, 65535, 90);  // one vertex per side
    repeat (3) begin
      run_phase($urandom_range(0, 80), $urandom_range(1, 64), $urandom_range(1, 64),
                $urandom_range(0, 65535), 90);
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_vertices.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/hhn_pkg.sv
hdl/heightmap_height_and_normal.sv
tb/tb.sv
